/* hdl/htc_pkg.sv */
// ----------------------------------------------------------------------------
// htc_pkg
// Shared types and constants of the per-host IPv4 traffic counter table.
// ----------------------------------------------------------------------------
package htc_pkg;

    localparam int TABLE_SIZE_DEF = 2048;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [6:0]  LINK_RESET = 7'd14;
    localparam logic [16:0] MIN_IP_HDR = 17'd20;
    localparam logic [3:0]  IP_V4      = 4'd4;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_SHORT   = 2'd1;
    localparam logic [1:0] STAT_BAD_VER = 2'd2;
    localparam logic [1:0] STAT_FRAG    = 2'd3;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        tcp;
        logic        udp;
        logic [31:0] src;
        logic [31:0] dst;
        logic [10:0] ridx;
    } t_cmd;

    typedef struct packed {
        logic [15:0] tx_udp;
        logic [15:0] rx_udp;
        logic [15:0] tx_tcp;
        logic [15:0] rx_tcp;
        logic [15:0] tx;
        logic [15:0] rx;
    } t_ctr;

endpackage

/* hdl/htc_ram.sv */
// ----------------------------------------------------------------------------
// htc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module htc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/htc_front.sv */
// ----------------------------------------------------------------------------
// htc_front
// Accepts request words, holds the link header size and classifies packets.
// ----------------------------------------------------------------------------
module htc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  logic [6:0]     i_cfg_data,
    input  logic           i_valid,
    input  logic           i_req_type,
    input  logic [15:0]    i_captured_length,
    input  logic [3:0]     i_ip_version,
    input  logic [12:0]    i_frag_offset,
    input  logic [7:0]     i_protocol,
    input  logic [31:0]    i_src_addr,
    input  logic [31:0]    i_dst_addr,
    input  logic [10:0]    i_read_index,
    input  logic           i_q_full,
    output logic           o_push,
    output htc_pkg::t_cmd  o_cmd
);

    logic [6:0]    r_link;
    logic [16:0]   min_len;
    htc_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= htc_pkg::LINK_RESET;
        end else if (i_cfg_wr) begin
            r_link <= i_cfg_data;
        end
    end

    assign min_len = 17'(r_link) + htc_pkg::MIN_IP_HDR;

    always_comb begin
        cmd        = '0;
        cmd.tcp    = (i_protocol == htc_pkg::PROTO_TCP);
        cmd.udp    = (i_protocol == htc_pkg::PROTO_UDP);
        cmd.src    = i_src_addr;
        cmd.dst    = i_dst_addr;
        cmd.ridx   = i_read_index;
        cmd.status = htc_pkg::STAT_OK;
        if (i_req_type) begin
            cmd.kind = htc_pkg::KIND_READ;
        end else if (17'(i_captured_length) < min_len) begin
            cmd.kind   = htc_pkg::KIND_DROP;
            cmd.status = htc_pkg::STAT_SHORT;
        end else if (i_ip_version != htc_pkg::IP_V4) begin
            cmd.kind   = htc_pkg::KIND_DROP;
            cmd.status = htc_pkg::STAT_BAD_VER;
        end else if (i_frag_offset != 13'd0) begin
            cmd.kind   = htc_pkg::KIND_DROP;
            cmd.status = htc_pkg::STAT_FRAG;
        end else begin
            cmd.kind = htc_pkg::KIND_COUNT;
        end
    end

    assign o_push = i_valid && !i_q_full;
    assign o_cmd  = cmd;

endmodule

/* hdl/htc_queue.sv */
// ----------------------------------------------------------------------------
// htc_queue
// Short command queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module htc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  htc_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output htc_pkg::t_cmd  o_head
);

    localparam int PW = (htc_pkg::QUEUE_DEPTH > 1) ? $clog2(htc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(htc_pkg::QUEUE_DEPTH + 1);

    htc_pkg::t_cmd r_slot [htc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(htc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CW'(htc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];

endmodule

/* hdl/htc_back.sv */
// ----------------------------------------------------------------------------
// htc_back
// Table engine: linear address search, slot claim, counter update, slot read.
// ----------------------------------------------------------------------------
module htc_back #(
    parameter int TABLE_SIZE = htc_pkg::TABLE_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  htc_pkg::t_cmd  i_q_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_status,
    output logic [10:0]    o_dst_slot,
    output logic [10:0]    o_src_slot,
    output logic [31:0]    o_entry_addr,
    output logic [15:0]    o_rx_count,
    output logic [15:0]    o_tx_count,
    output logic [15:0]    o_rx_tcp_count,
    output logic [15:0]    o_tx_tcp_count,
    output logic [15:0]    o_rx_udp_count,
    output logic [15:0]    o_tx_udp_count,
    output logic [10:0]    o_slots_used
);

    localparam int        IW  = $clog2(TABLE_SIZE);
    localparam logic [IW-1:0] MAX = IW'(TABLE_SIZE - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CRD  = 3'd3;
    localparam logic [2:0] S_CWR  = 3'd4;
    localparam logic [2:0] S_RDW  = 3'd5;
    localparam logic [2:0] S_RDD  = 3'd6;

    logic [2:0]    r_state,   n_state;
    htc_pkg::t_cmd r_cmd,     n_cmd;
    logic          r_phase,   n_phase;
    logic [IW:0]   r_scan,    n_scan;
    logic          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic [IW-1:0] r_slot,    n_slot;
    logic          r_new,     n_new;
    logic [IW-1:0] r_highest, n_highest;
    logic [10:0]   r_dst_slot, n_dst_slot;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status,   n_status;
    logic [10:0]   r_o_dst,    n_o_dst;
    logic [10:0]   r_o_src,    n_o_src;
    logic [31:0]   r_o_addr,   n_o_addr;
    htc_pkg::t_ctr r_o_ctr,    n_o_ctr;
    logic [10:0]   r_o_used,   n_o_used;

    logic          a_wr_en;
    logic [IW-1:0] a_wr_addr;
    logic [31:0]   a_wr_data;
    logic [IW-1:0] a_rd_addr;
    logic [31:0]   a_rd_data;
    logic          c_wr_en;
    logic [IW-1:0] c_wr_addr;
    htc_pkg::t_ctr c_wr_data;
    logic [IW-1:0] c_rd_addr;
    htc_pkg::t_ctr c_rd_data;

    logic [31:0]   key;
    logic          pop;
    htc_pkg::t_ctr base;
    htc_pkg::t_ctr bumped;

    htc_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_addr_ram (
        .i_clk    (i_clk),
        .i_wr_en  (a_wr_en),
        .i_wr_addr(a_wr_addr),
        .i_wr_data(a_wr_data),
        .i_rd_addr(a_rd_addr),
        .o_rd_data(a_rd_data)
    );

    htc_ram #(.WIDTH($bits(htc_pkg::t_ctr)), .DEPTH(TABLE_SIZE)) u_ctr_ram (
        .i_clk    (i_clk),
        .i_wr_en  (c_wr_en),
        .i_wr_addr(c_wr_addr),
        .i_wr_data(c_wr_data),
        .i_rd_addr(c_rd_addr),
        .o_rd_data(c_rd_data)
    );

    assign key = r_phase ? r_cmd.src : r_cmd.dst;
    assign pop = (r_state == S_IDLE) && !i_q_empty && !r_out_valid;

    always_comb begin
        base   = r_new ? '0 : c_rd_data;
        bumped = base;
        if (r_phase) begin
            bumped.tx     = base.tx + 16'd1;
            bumped.tx_tcp = base.tx_tcp + 16'(r_cmd.tcp);
            bumped.tx_udp = base.tx_udp + 16'(r_cmd.udp);
        end else begin
            bumped.rx     = base.rx + 16'd1;
            bumped.rx_tcp = base.rx_tcp + 16'(r_cmd.tcp);
            bumped.rx_udp = base.rx_udp + 16'(r_cmd.udp);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_phase     = r_phase;
        n_scan      = r_scan;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_slot      = r_slot;
        n_new       = r_new;
        n_highest   = r_highest;
        n_dst_slot  = r_dst_slot;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_o_dst     = r_o_dst;
        n_o_src     = r_o_src;
        n_o_addr    = r_o_addr;
        n_o_ctr     = r_o_ctr;
        n_o_used    = r_o_used;
        a_wr_en     = 1'b0;
        a_wr_addr   = r_slot;
        a_wr_data   = key;
        a_rd_addr   = r_scan[IW-1:0];
        c_wr_en     = 1'b0;
        c_wr_addr   = r_slot;
        c_wr_data   = bumped;
        c_rd_addr   = r_slot;

        case (r_state)
            S_INIT: begin
                // slot 0 holds address zero from reset
                a_wr_en   = 1'b1;
                a_wr_addr = '0;
                a_wr_data = '0;
                c_wr_en   = 1'b1;
                c_wr_addr = '0;
                c_wr_data = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (pop) begin
                    n_cmd     = i_q_head;
                    n_phase   = 1'b0;
                    n_scan    = '0;
                    case (i_q_head.kind)
                        htc_pkg::KIND_READ:  n_state = S_RDW;
                        htc_pkg::KIND_COUNT: n_state = S_SCAN;
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = i_q_head.status;
                            n_o_dst     = '0;
                            n_o_src     = '0;
                            n_o_addr    = '0;
                            n_o_ctr     = '0;
                            n_o_used    = 11'(r_highest);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_scan <= {1'b0, r_highest}) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan[IW-1:0];
                    n_scan    = r_scan + 1'b1;
                end
                if (r_cmp_vld) begin
                    if (a_rd_data == key) begin
                        n_slot    = r_cmp_idx;
                        n_new     = 1'b0;
                        n_cmp_vld = 1'b0;
                        n_state   = S_CRD;
                    end else if (r_cmp_idx == r_highest) begin
                        // miss: claim the next slot, or reuse the last one when full
                        a_wr_en = 1'b1;
                        if (r_highest != MAX) begin
                            n_highest = r_highest + 1'b1;
                            a_wr_addr = r_highest + 1'b1;
                            n_slot    = r_highest + 1'b1;
                            n_new     = 1'b1;
                        end else begin
                            a_wr_addr = MAX;
                            n_slot    = MAX;
                            n_new     = 1'b0;
                        end
                        n_cmp_vld = 1'b0;
                        n_state   = S_CRD;
                    end
                end
            end
            S_CRD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                c_wr_en = 1'b1;
                if (!r_phase) begin
                    n_dst_slot = 11'(r_slot);
                    n_phase    = 1'b1;
                    n_scan     = '0;
                    n_state    = S_SCAN;
                end else begin
                    n_out_valid = 1'b1;
                    n_status    = htc_pkg::STAT_OK;
                    n_o_dst     = r_dst_slot;
                    n_o_src     = 11'(r_slot);
                    n_o_addr    = '0;
                    n_o_ctr     = '0;
                    n_o_used    = 11'(r_highest);
                    n_state     = S_IDLE;
                end
            end
            S_RDW: begin
                a_rd_addr = IW'(r_cmd.ridx);
                c_rd_addr = IW'(r_cmd.ridx);
                n_state   = S_RDD;
            end
            S_RDD: begin
                n_out_valid = 1'b1;
                n_status    = htc_pkg::STAT_OK;
                n_o_dst     = '0;
                n_o_src     = '0;
                n_o_used    = 11'(r_highest);
                // slots above the highest claimed one were never written
                if (32'(r_cmd.ridx) > 32'(r_highest)) begin
                    n_o_addr = '0;
                    n_o_ctr  = '0;
                end else begin
                    n_o_addr = a_rd_data;
                    n_o_ctr  = c_rd_data;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cmp_vld   <= 1'b0;
            r_highest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_highest   <= n_highest;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_phase    <= n_phase;
        r_scan     <= n_scan;
        r_cmp_idx  <= n_cmp_idx;
        r_slot     <= n_slot;
        r_new      <= n_new;
        r_dst_slot <= n_dst_slot;
        r_status   <= n_status;
        r_o_dst    <= n_o_dst;
        r_o_src    <= n_o_src;
        r_o_addr   <= n_o_addr;
        r_o_ctr    <= n_o_ctr;
        r_o_used   <= n_o_used;
    end

    assign o_pop          = pop;
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_dst_slot     = r_o_dst;
    assign o_src_slot     = r_o_src;
    assign o_entry_addr   = r_o_addr;
    assign o_rx_count     = r_o_ctr.rx;
    assign o_tx_count     = r_o_ctr.tx;
    assign o_rx_tcp_count = r_o_ctr.rx_tcp;
    assign o_tx_tcp_count = r_o_ctr.tx_tcp;
    assign o_rx_udp_count = r_o_ctr.rx_udp;
    assign o_tx_udp_count = r_o_ctr.tx_udp;
    assign o_slots_used   = r_o_used;

    a_highest_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |->
        (r_highest == $past(r_highest) || r_highest == $past(r_highest) + 1'b1))
        else $error("highest slot moved by more than one");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_cmp_idx <= r_highest))
        else $error("compare beyond highest slot");

    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state != S_IDLE) || r_out_valid)
        else $error("popped word produced no work");

endmodule

/* hdl/ip_host_traffic_counter_table_core.sv */
// ----------------------------------------------------------------------------
// ip_host_traffic_counter_table_core
// Per-host IPv4 packet statistics table with a one-slot read request.
// ----------------------------------------------------------------------------
// Each word yields one result. A counted packet runs two linear searches
// through the address RAM, one slot per cycle from slot 0 to the highest
// claimed slot h, each followed by a counter read-modify-write. After reset
// the block sets up slot 0 in its init state before it takes work from its
// queue; up to two words are buffered.
// ----------------------------------------------------------------------------
module ip_host_traffic_counter_table_core #(
    parameter int TABLE_SIZE = htc_pkg::TABLE_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_captured_length,
    input  logic [3:0]  i_ip_version,
    input  logic [12:0] i_frag_offset,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [10:0] i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [10:0] o_dst_slot,
    output logic [10:0] o_src_slot,
    output logic [31:0] o_entry_addr,
    output logic [15:0] o_rx_count,
    output logic [15:0] o_tx_count,
    output logic [15:0] o_rx_tcp_count,
    output logic [15:0] o_tx_tcp_count,
    output logic [15:0] o_rx_udp_count,
    output logic [15:0] o_tx_udp_count,
    output logic [10:0] o_slots_used
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    htc_pkg::t_cmd cmd;
    htc_pkg::t_cmd head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;

    htc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .i_req_type       (i_req_type),
        .i_captured_length(i_captured_length),
        .i_ip_version     (i_ip_version),
        .i_frag_offset    (i_frag_offset),
        .i_protocol       (i_protocol),
        .i_src_addr       (i_src_addr),
        .i_dst_addr       (i_dst_addr),
        .i_read_index     (i_read_index),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    htc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (head)
    );

    htc_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_dst_slot    (o_dst_slot),
        .o_src_slot    (o_src_slot),
        .o_entry_addr  (o_entry_addr),
        .o_rx_count    (o_rx_count),
        .o_tx_count    (o_tx_count),
        .o_rx_tcp_count(o_rx_tcp_count),
        .o_tx_tcp_count(o_tx_tcp_count),
        .o_rx_udp_count(o_rx_udp_count),
        .o_tx_udp_count(o_tx_udp_count),
        .o_slots_used  (o_slots_used)
    );

endmodule

/* test/ip_host_traffic_counter_table_core_tb.sv */
// ----------------------------------------------------------------------------
// ip_host_traffic_counter_table_core_tb
// Sends packet updates and slot reads under random idling on both sides and
// compares every result word against a behavioral model of the table.
// ----------------------------------------------------------------------------
module ip_host_traffic_counter_table_core_tb;

    localparam int TSIZE = htc_pkg::TABLE_SIZE_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]    status;
        logic [10:0]   dst_slot;
        logic [10:0]   src_slot;
        logic [31:0]   entry_addr;
        htc_pkg::t_ctr ctr;
        logic [10:0]   slots_used;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [15:0] i_captured_length;
    logic [3:0]  i_ip_version;
    logic [12:0] i_frag_offset;
    logic [7:0]  i_protocol;
    logic [31:0] i_src_addr;
    logic [31:0] i_dst_addr;
    logic [10:0] i_read_index;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [10:0] o_dst_slot;
    logic [10:0] o_src_slot;
    logic [31:0] o_entry_addr;
    logic [15:0] o_rx_count;
    logic [15:0] o_tx_count;
    logic [15:0] o_rx_tcp_count;
    logic [15:0] o_tx_tcp_count;
    logic [15:0] o_rx_udp_count;
    logic [15:0] o_tx_udp_count;
    logic [10:0] o_slots_used;

    ip_host_traffic_counter_table_core DUT (.*);

    // model state
    logic [31:0]   host_addr [TSIZE];
    htc_pkg::t_ctr host_ctr [TSIZE];
    logic [10:0]   top_slot;
    logic [6:0]    link_bytes;

    t_res expected_q[$];
    int   mismatches;
    int   watchdog;
    int   stall_left;
    bit   rx_idle_on;
    bit   tx_idle_on;
    bit   timed_out;

    always #10 i_clk = ~i_clk;

    function automatic logic [10:0] claim_slot(logic [31:0] addr);
        for (int s = 0; s <= top_slot; s++) begin
            if (host_addr[s] == addr) return s[10:0];
        end
        if (top_slot < TSIZE - 1) top_slot = top_slot + 11'd1;
        host_addr[top_slot] = addr;
        return top_slot;
    endfunction

    function automatic logic [10:0] bump_host(logic [31:0] addr, logic [7:0] proto,
                                              bit sending);
        logic [10:0] s;
        s = claim_slot(addr);
        if (sending) begin
            host_ctr[s].tx++;
            if (proto == htc_pkg::PROTO_TCP) host_ctr[s].tx_tcp++;
            else if (proto == htc_pkg::PROTO_UDP) host_ctr[s].tx_udp++;
        end else begin
            host_ctr[s].rx++;
            if (proto == htc_pkg::PROTO_TCP) host_ctr[s].rx_tcp++;
            else if (proto == htc_pkg::PROTO_UDP) host_ctr[s].rx_udp++;
        end
        return s;
    endfunction

    function automatic t_res predict_word(bit rd, logic [15:0] len, logic [3:0] ver,
                                          logic [12:0] frag, logic [7:0] proto,
                                          logic [31:0] src, logic [31:0] dst,
                                          logic [10:0] ridx);
        t_res r;
        r = '0;
        if (rd) begin
            r.entry_addr = host_addr[ridx];
            r.ctr = host_ctr[ridx];
        end else if ({1'b0, len} < {10'd0, link_bytes} + htc_pkg::MIN_IP_HDR) begin
            r.status = htc_pkg::STAT_SHORT;
        end else if (ver != htc_pkg::IP_V4) begin
            r.status = htc_pkg::STAT_BAD_VER;
        end else if (frag != 0) begin
            r.status = htc_pkg::STAT_FRAG;
        end else begin
            r.dst_slot = bump_host(dst, proto, 1'b0);
            r.src_slot = bump_host(src, proto, 1'b1);
        end
        r.slots_used = top_slot;
        return r;
    endfunction

    // send one word; blocks until accepted, valid stays up for the next word
    task automatic send_word(bit rd, logic [15:0] len, logic [3:0] ver,
                             logic [12:0] frag, logic [7:0] proto,
                             logic [31:0] src, logic [31:0] dst, logic [10:0] ridx);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_req_type        <= rd;
        i_captured_length <= len;
        i_ip_version      <= ver;
        i_frag_offset     <= frag;
        i_protocol        <= proto;
        i_src_addr        <= src;
        i_dst_addr        <= dst;
        i_read_index      <= ridx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(predict_word(rd, len, ver, frag, proto, src, dst, ridx));
    endtask

    task automatic send_packet(logic [31:0] src, logic [31:0] dst, logic [7:0] proto);
        send_word(0, 16'd1500, htc_pkg::IP_V4, 13'd0, proto, src, dst, 11'd0);
    endtask

    task automatic send_read(logic [10:0] ridx);
        send_word(1, 16'($urandom), 4'($urandom), 13'($urandom), 8'($urandom),
                  $urandom, $urandom, ridx);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_link_bytes(logic [6:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        link_bytes = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_rejects;
        send_word(0, 16'd33, htc_pkg::IP_V4, 0, htc_pkg::PROTO_TCP, 1, 2, 0);
        send_word(0, 16'd34, 4'd6, 0, htc_pkg::PROTO_TCP, 1, 2, 0);
        send_word(0, 16'd0, 4'd15, 13'h1fff, 8'hff, 32'hffffffff, 0, 11'h7ff);
        send_word(0, 16'hffff, 4'd0, 13'd1, htc_pkg::PROTO_UDP, 5, 6, 0);
        send_word(0, 16'hffff, htc_pkg::IP_V4, 13'h1fff, htc_pkg::PROTO_UDP, 5, 6, 0);
        send_word(0, 16'd34, htc_pkg::IP_V4, 0, htc_pkg::PROTO_TCP, 32'hffffffff, 0, 0);
    endtask

    task automatic test_counting;
        send_packet(32'h0a000001, 32'h0a000002, htc_pkg::PROTO_TCP);
        send_packet(32'h0a000002, 32'h0a000001, htc_pkg::PROTO_UDP);
        send_packet(32'h0a000001, 32'h0a000001, 8'd1);
        send_packet(0, 0, htc_pkg::PROTO_UDP);
        send_word(0, 16'hffff, htc_pkg::IP_V4, 0, 8'hff, 32'h0a000003, 32'hffffffff, 0);
        for (int i = 0; i < 6; i++) send_read(i[10:0]);
        send_read(11'h7ff);
    endtask

    task automatic test_link_header;
        write_link_bytes(7'd0);
        send_word(0, 16'd19, htc_pkg::IP_V4, 0, htc_pkg::PROTO_TCP, 1, 2, 0);
        send_word(0, 16'd20, htc_pkg::IP_V4, 0, htc_pkg::PROTO_TCP, 1, 2, 0);
        write_link_bytes(7'd127);
        send_word(0, 16'd146, htc_pkg::IP_V4, 0, htc_pkg::PROTO_TCP, 1, 2, 0);
        send_word(0, 16'd147, htc_pkg::IP_V4, 0, htc_pkg::PROTO_TCP, 1, 2, 0);
        write_link_bytes(7'd64);
        send_word(0, 16'd83, htc_pkg::IP_V4, 0, htc_pkg::PROTO_UDP, 3, 4, 0);
        send_word(0, 16'd84, htc_pkg::IP_V4, 0, htc_pkg::PROTO_UDP, 3, 4, 0);
        write_link_bytes(htc_pkg::LINK_RESET);
    endtask

    // mostly well-formed packets over a small host pool so searches stay short
    task automatic test_random(int n);
        logic [31:0] pool [24];
        int          k;
        for (int i = 0; i < 24; i++) pool[i] = $urandom;
        pool[0] = 32'hffffffff;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 15) begin
                send_read(11'($urandom_range(0, 40)));
            end else if (k < 25) begin
                send_word(0, 16'($urandom), 4'($urandom), 13'($urandom), 8'($urandom),
                          $urandom, $urandom, 11'($urandom));
            end else if (k < 30) begin
                send_word(0, 16'($urandom_range(0, 40)), htc_pkg::IP_V4, 0, 8'($urandom),
                          pool[$urandom_range(0, 23)], pool[$urandom_range(0, 23)], 0);
            end else begin
                send_word(0, 16'($urandom_range(34, 65535)), htc_pkg::IP_V4, 0,
                          $urandom_range(0, 2) == 0 ? htc_pkg::PROTO_TCP :
                          ($urandom_range(0, 1) ? htc_pkg::PROTO_UDP : 8'($urandom)),
                          pool[$urandom_range(0, 23)], pool[$urandom_range(0, 23)],
                          11'($urandom));
            end
            if (i == n / 2) drain();
        end
    endtask

    // output side: random stall bursts and result check
    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_status, o_dst_slot, o_src_slot, o_entry_addr,
                        '{o_tx_udp_count, o_rx_udp_count, o_tx_tcp_count,
                          o_rx_tcp_count, o_tx_count, o_rx_count}, o_slots_used};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            i_stall <= (stall_left != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        for (int i = 0; i < TSIZE; i++) begin
            host_addr[i] = '0;
            host_ctr[i] = '0;
        end
        top_slot = '0;
        link_bytes = htc_pkg::LINK_RESET;
        mismatches = 0;
        watchdog = 0;
        timed_out = 0;
        rx_idle_on = 1;
        tx_idle_on = 1;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_req_type <= 1'b0;
        i_captured_length <= '0;
        i_ip_version <= '0;
        i_frag_offset <= '0;
        i_protocol <= '0;
        i_src_addr <= '0;
        i_dst_addr <= '0;
        i_read_index <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rejects();
        test_counting();
        test_link_header();
        test_random(900);
        write_link_bytes(7'($urandom_range(0, 64)));
        test_random(100);
        rx_idle_on = 0;
        tx_idle_on = 0;
        test_random(100);
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/htc_pkg.sv
hdl/htc_ram.sv
hdl/htc_front.sv
hdl/htc_queue.sv
hdl/htc_back.sv
hdl/ip_host_traffic_counter_table_core.sv
test/ip_host_traffic_counter_table_core_tb.sv
